/* src/tagged_usage_counters_with_peak_assert.svh */
// assertion shorthands used by the checker file
`ifndef TAGGED_USAGE_COUNTERS_WITH_PEAK_ASSERT_SVH
`define TAGGED_USAGE_COUNTERS_WITH_PEAK_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define TUC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define TUC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/tuc_pkg.sv */
package tuc_pkg;

  // defaults for the top-level parameters
  localparam int MAX_TAGS_DEF        = 64;
  localparam int BYTE_COUNT_BITS_DEF = 48;

  // fixed field widths
  localparam int TAG_W      = 6;
  localparam int AMOUNT_W   = 32;
  localparam int OUT_BYTE_W = 48;
  localparam int ALLOC_W    = 32;
  localparam int CFG_W      = 7;

  localparam logic [CFG_W-1:0] TAGS_IN_USE_RESET = 7'd64;

  typedef enum logic [1:0] {
    ACT_CHARGE,
    ACT_DISCHARGE,
    ACT_READ,
    ACT_RESET_PEAKS
  } action_t;

  typedef struct packed {
    action_t             action;
    logic [TAG_W-1:0]    tag;
    logic [AMOUNT_W-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic                  tag_in_range;
    logic [OUT_BYTE_W-1:0] tag_live;
    logic [OUT_BYTE_W-1:0] tag_peak;
    logic [ALLOC_W-1:0]    tag_allocations;
    logic [OUT_BYTE_W-1:0] total_live;
    logic [OUT_BYTE_W-1:0] total_peak;
    logic [ALLOC_W-1:0]    total_allocations;
  } out_item_t;

  // what the update unit needs to know about the item
  typedef struct packed {
    action_t action;
    logic    ok;
  } upd_ctrl_t;

endpackage

/* src/tuc_ram.sv */
module tuc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* src/tuc_update.sv */
module tuc_update #(
  parameter int BW = tuc_pkg::BYTE_COUNT_BITS_DEF,
  localparam int ENT_W = 2 * BW + tuc_pkg::ALLOC_W
) (
  input  tuc_pkg::upd_ctrl_t                  ctrl,
  input  logic [tuc_pkg::AMOUNT_W-1:0]        amount,
  input  logic [ENT_W-1:0]                    entry,
  input  logic [BW-1:0]                       sum_live,
  input  logic [BW-1:0]                       sum_peak,
  input  logic [tuc_pkg::ALLOC_W-1:0]         sum_allocs,
  output logic [ENT_W-1:0]                    entry_next,
  output logic                                wr,
  output logic [BW-1:0]                       sum_live_next,
  output logic [BW-1:0]                       sum_peak_next,
  output logic [tuc_pkg::ALLOC_W-1:0]         sum_allocs_next
);

  logic [BW-1:0]               live;
  logic [BW-1:0]               peak;
  logic [tuc_pkg::ALLOC_W-1:0] alloc;
  logic [BW-1:0]               amt;
  logic [BW-1:0]               live_new;
  logic [BW-1:0]               peak_new;
  logic [tuc_pkg::ALLOC_W-1:0] alloc_new;

  // entry layout: live on top, then peak, then allocations
  assign live  = entry[ENT_W-1 -: BW];
  assign peak  = entry[BW+tuc_pkg::ALLOC_W-1 -: BW];
  assign alloc = entry[tuc_pkg::ALLOC_W-1:0];
  assign amt   = BW'(amount);

  // charge raises peaks, discharge leaves them, others pass through
  always_comb begin
    live_new        = live;
    peak_new        = peak;
    alloc_new       = alloc;
    sum_live_next   = sum_live;
    sum_peak_next   = sum_peak;
    sum_allocs_next = sum_allocs;
    wr              = 1'b0;
    if (ctrl.ok) begin
      unique case (ctrl.action)
        tuc_pkg::ACT_CHARGE: begin
          live_new        = live + amt;
          alloc_new       = alloc + 32'd1;
          peak_new        = (peak < live_new) ? live_new : peak;
          sum_live_next   = sum_live + amt;
          sum_allocs_next = sum_allocs + 32'd1;
          sum_peak_next   = (sum_peak < sum_live_next) ? sum_live_next : sum_peak;
          wr              = 1'b1;
        end
        tuc_pkg::ACT_DISCHARGE: begin
          live_new        = live - amt;
          alloc_new       = alloc - 32'd1;
          sum_live_next   = sum_live - amt;
          sum_allocs_next = sum_allocs - 32'd1;
          wr              = 1'b1;
        end
        default: begin
          wr = 1'b0;
        end
      endcase
    end
  end

  assign entry_next = {live_new, peak_new, alloc_new};

endmodule

/* src/tagged_usage_counters_with_peak.sv */
// Per-tag usage counters (live bytes, peak, outstanding allocations) in one
// on-chip counter memory of MAX_TAGS entries with a registered read, plus a
// grand total in registers. After reset a clearing pass zeroes every entry;
// in_ready stays low during it. Charge, discharge and read items read the
// tag's entry, then, once the result register is free, load the result; an
// in-range charge or discharge also writes the updated entry back. Items go
// one at a time, so back-to-back accesses to the same tag never overlap in
// the memory. A reset-peaks item copies total live to total peak, walks tags
// below limit (tags_in_use capped at MAX_TAGS) one per cycle copying live
// into peak, then reports like a read. A new item is taken while the previous
// result still waits on out_ready. tags_in_use is written through cfg_wr_en /
// cfg_wr_data and must only change while the block is idle.
module tagged_usage_counters_with_peak #(
  parameter int MAX_TAGS        = tuc_pkg::MAX_TAGS_DEF,
  parameter int BYTE_COUNT_BITS = tuc_pkg::BYTE_COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [tuc_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tuc_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tuc_pkg::out_item_t          out_item
);

  localparam int BW    = BYTE_COUNT_BITS;
  localparam int AW    = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
  localparam int LW    = (AW + 1 > tuc_pkg::CFG_W) ? AW + 1 : tuc_pkg::CFG_W;
  localparam int ENT_W = 2 * BW + tuc_pkg::ALLOC_W;
  localparam int OW    = tuc_pkg::OUT_BYTE_W;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SWEEP
  } state_t;

  state_t                         state;
  logic [tuc_pkg::CFG_W-1:0]      tags_in_use;
  logic [LW-1:0]                  limit;
  logic [LW-1:0]                  clr;
  logic [LW-1:0]                  swp;
  logic                           swp_wv;
  logic [AW-1:0]                  swp_wa;
  logic                           swp_more;

  tuc_pkg::action_t               cur_action;
  logic [tuc_pkg::TAG_W-1:0]      cur_tag;
  logic [tuc_pkg::AMOUNT_W-1:0]   cur_amount;
  logic                           ok;
  logic [AW+tuc_pkg::TAG_W-1:0]   in_tag_ext;
  logic [AW+tuc_pkg::TAG_W-1:0]   cur_tag_ext;
  logic [AW-1:0]                  in_addr;
  logic [AW-1:0]                  cur_addr;

  logic [BW-1:0]                  sum_live;
  logic [BW-1:0]                  sum_peak;
  logic [tuc_pkg::ALLOC_W-1:0]    sum_allocs;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [ENT_W-1:0]               ram_wdata;
  logic [AW-1:0]                  ram_raddr;
  logic [ENT_W-1:0]               ram_rdata;

  tuc_pkg::upd_ctrl_t             upd_ctrl;
  logic [ENT_W-1:0]               upd_entry;
  logic                           upd_wr;
  logic [BW-1:0]                  upd_sum_live;
  logic [BW-1:0]                  upd_sum_peak;
  logic [tuc_pkg::ALLOC_W-1:0]    upd_sum_allocs;

  logic                           out_free;
  logic                           out_load;
  tuc_pkg::out_item_t             out_next;
  logic [BW+OW-1:0]               ext_tag_live;
  logic [BW+OW-1:0]               ext_tag_peak;
  logic [BW+OW-1:0]               ext_sum_live;
  logic [BW+OW-1:0]               ext_sum_peak;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      tags_in_use <= tuc_pkg::TAGS_IN_USE_RESET;
    end else if (cfg_wr_en) begin
      tags_in_use <= cfg_wr_data;
    end
  end

  // effective tag count, capped at the memory depth
  always_comb begin
    if (LW'(tags_in_use) > LW'(MAX_TAGS)) begin
      limit = LW'(MAX_TAGS);
    end else begin
      limit = LW'(tags_in_use);
    end
  end

  // tag to memory address
  assign in_tag_ext  = {{AW{1'b0}}, in_item.tag};
  assign cur_tag_ext = {{AW{1'b0}}, cur_tag};
  assign in_addr     = in_tag_ext[AW-1:0];
  assign cur_addr    = cur_tag_ext[AW-1:0];
  assign ok          = LW'(cur_tag) < limit;
  assign swp_more    = swp < limit;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign out_load = (state == S_EXEC) && (cur_action != tuc_pkg::ACT_RESET_PEAKS) && out_free;

  // read address selection
  always_comb begin
    unique case (state)
      S_IDLE:  ram_raddr = in_addr;
      S_SWEEP: ram_raddr = swp_more ? swp[AW-1:0] : cur_addr;
      default: ram_raddr = cur_addr;
    endcase
  end

  // write port: clearing pass, write-back of an update, or peak sweep
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = upd_entry;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr[AW-1:0];
        ram_wdata = '0;
      end
      S_EXEC: begin
        ram_we = out_free && upd_wr;
      end
      S_SWEEP: begin
        ram_we    = swp_wv;
        ram_waddr = swp_wa;
        ram_wdata = {ram_rdata[ENT_W-1 -: BW], ram_rdata[ENT_W-1 -: BW],
                     ram_rdata[tuc_pkg::ALLOC_W-1:0]};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tuc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_TAGS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign upd_ctrl.action = cur_action;
  assign upd_ctrl.ok     = ok;

  tuc_update #(
    .BW (BW)
  ) u_update (
    .ctrl            (upd_ctrl),
    .amount          (cur_amount),
    .entry           (ram_rdata),
    .sum_live        (sum_live),
    .sum_peak        (sum_peak),
    .sum_allocs      (sum_allocs),
    .entry_next      (upd_entry),
    .wr              (upd_wr),
    .sum_live_next   (upd_sum_live),
    .sum_peak_next   (upd_sum_peak),
    .sum_allocs_next (upd_sum_allocs)
  );

  // result fields, byte counters fitted to the 48-bit outputs
  assign ext_tag_live = {{OW{1'b0}}, upd_entry[ENT_W-1 -: BW]};
  assign ext_tag_peak = {{OW{1'b0}}, upd_entry[BW+tuc_pkg::ALLOC_W-1 -: BW]};
  assign ext_sum_live = {{OW{1'b0}}, upd_sum_live};
  assign ext_sum_peak = {{OW{1'b0}}, upd_sum_peak};

  always_comb begin
    out_next.tag_in_range      = ok;
    out_next.tag_live          = ok ? ext_tag_live[OW-1:0] : '0;
    out_next.tag_peak          = ok ? ext_tag_peak[OW-1:0] : '0;
    out_next.tag_allocations   = ok ? upd_entry[tuc_pkg::ALLOC_W-1:0] : '0;
    out_next.total_live        = ext_sum_live[OW-1:0];
    out_next.total_peak        = ext_sum_peak[OW-1:0];
    out_next.total_allocations = upd_sum_allocs;
  end

  // sequencer, totals and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr        <= '0;
      swp        <= '0;
      swp_wv     <= 1'b0;
      out_valid  <= 1'b0;
      sum_live   <= '0;
      sum_peak   <= '0;
      sum_allocs <= '0;
    end else begin
      // drop a taken result unless a new one loads now
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + LW'(1);
          if (clr == LW'(MAX_TAGS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cur_action <= in_item.action;
            cur_tag    <= in_item.tag;
            cur_amount <= in_item.amount;
            state      <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cur_action == tuc_pkg::ACT_RESET_PEAKS) begin
            sum_peak <= sum_live;
            swp      <= '0;
            swp_wv   <= 1'b0;
            state    <= S_SWEEP;
          end else if (out_free) begin
            sum_live   <= upd_sum_live;
            sum_peak   <= upd_sum_peak;
            sum_allocs <= upd_sum_allocs;
            out_item   <= out_next;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_SWEEP: begin
          // read tag swp now, copy its live into its peak next cycle
          swp_wv <= swp_more;
          swp_wa <= swp[AW-1:0];
          if (swp_more) begin
            swp <= swp + LW'(1);
          end else if (!swp_wv) begin
            // addressed entry is being read now; report it like a read
            cur_action <= tuc_pkg::ACT_READ;
            state      <= S_EXEC;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/tuc_checker.sv */
`include "tagged_usage_counters_with_peak_assert.svh"

module tuc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input tuc_pkg::out_item_t out_item
);

  logic                        have_prev;
  logic [tuc_pkg::ALLOC_W-1:0] prev_allocs;
  logic [tuc_pkg::ALLOC_W-1:0] alloc_step;
  logic                        in_fire;

  assign in_fire    = in_valid && in_ready;
  assign alloc_step = out_item.total_allocations - prev_allocs;

  // total allocations of the last delivered result
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
    end else if (out_valid && out_ready) begin
      have_prev   <= 1'b1;
      prev_allocs <= out_item.total_allocations;
    end
  end

  // a stalled result holds
  `TUC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_item), "result changed while stalled")

  // one item in work at a time
  `TUC_ASSERT_NEXT(a_busy_after_accept, in_fire,
    !in_ready, "item taken while another is in work")

  // out-of-range tag reads as zeros
  `TUC_ASSERT_NOW(a_range_zero, out_valid && !out_item.tag_in_range,
    out_item.tag_live == '0 && out_item.tag_peak == '0 &&
    out_item.tag_allocations == '0, "out-of-range tag fields not zero")

  // total allocations move by at most one per item
  `TUC_ASSERT_NOW(a_alloc_step, out_valid && out_ready && have_prev,
    alloc_step == 32'd0 || alloc_step == 32'd1 || alloc_step == 32'hFFFF_FFFF,
    "total allocations jumped")

endmodule

bind tagged_usage_counters_with_peak tuc_checker u_tuc_checker (.*);
